// File: hw/rtl/assembly_text_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text tokenizer
// Concurrent assertion wrappers clocked on i_clk, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSEMBLY_TEXT_TOKENIZER_ASSERT_SVH
`define ASSEMBLY_TEXT_TOKENIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked only while reset is released.
`define ATT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ATT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ATT_ASSERT(lbl, prop, msg)
`define ATT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/atok_pkg.sv
// ----------------------------------------------------------------------------
// Tokenizer package
// Shared widths, token kinds, character codes and result types.
// ----------------------------------------------------------------------------
package atok_pkg;

    localparam int VALUE_BITS_DEF    = 32;
    localparam int POSITION_BITS_DEF = 16;

    localparam int TEXT_W    = 8;
    localparam int KIND_W    = 3;
    localparam int POS_OUT_W = 16;
    localparam int LEN_OUT_W = 16;
    localparam int VAL_OUT_W = 32;
    localparam int FIELD_W   = POS_OUT_W + LEN_OUT_W + VAL_OUT_W + 1;
    localparam int DATA_W    = ((FIELD_W + 7) / 8) * 8;
    localparam int PAD_W     = DATA_W - FIELD_W;

    // Result queue depth; a power of two so the pointers wrap on their own.
    localparam int FIFO_DEPTH = 4;

    localparam logic [TEXT_W-1:0] CH_NUL   = 8'h00;
    localparam logic [TEXT_W-1:0] CH_LF    = 8'h0A;
    localparam logic [TEXT_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [TEXT_W-1:0] CH_COLON = 8'h3A;
    localparam logic [TEXT_W-1:0] CH_0     = 8'h30;
    localparam logic [TEXT_W-1:0] CH_9     = 8'h39;
    localparam logic [TEXT_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [TEXT_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [TEXT_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [TEXT_W-1:0] CH_UP_Z  = 8'h5A;

    typedef enum logic [KIND_W-1:0] {
        KIND_WORD,
        KIND_NUMBER,
        KIND_SYMBOL,
        KIND_EOL,
        KIND_EOT
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [POS_OUT_W-1:0]  start;
        logic [LEN_OUT_W-1:0]  length;
        logic [VAL_OUT_W-1:0]  value;
        logic                  sat;
        logic                  last;
    } t_token;

    // Results produced by one accepted byte: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_emit;

endpackage

// File: hw/rtl/atok_scanner.sv
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Classifies each byte, updates the pending token and emits up to two results.
// ----------------------------------------------------------------------------
module atok_scanner #(
    parameter int VALUE_BITS    = atok_pkg::VALUE_BITS_DEF,
    parameter int POSITION_BITS = atok_pkg::POSITION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [atok_pkg::TEXT_W-1:0] i_byte,
    output atok_pkg::t_emit             o_emit
);
    import atok_pkg::*;

    localparam int VW = VALUE_BITS + 4;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_WORD
    } t_mode;

    t_mode                    r_mode,  n_mode;
    logic [POSITION_BITS-1:0] r_pos,   n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [POSITION_BITS-1:0] r_len,   n_len;
    logic [VALUE_BITS-1:0]    r_val,   n_val;
    logic                     r_ovf,   n_ovf;

    logic          is_digit;
    logic          is_letter;
    logic [3:0]    digit_val;
    logic [VW-1:0] ext_val;
    logic [VW-1:0] mul_val;
    logic          len_full;

    assign is_digit  = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign is_letter = ((i_byte >= CH_LO_A) && (i_byte <= CH_LO_Z)) ||
                       ((i_byte >= CH_UP_A) && (i_byte <= CH_UP_Z));
    assign digit_val = 4'(i_byte - CH_0);
    assign ext_val   = VW'(r_val);
    // value * 10 + digit; any bit above the value width means overflow.
    assign mul_val   = (ext_val << 3) + (ext_val << 1) + VW'(digit_val);
    assign len_full  = (r_len == '1);

    always_comb begin
        t_token tok_a;
        t_token tok_b;
        logic   has_a;
        logic   has_b;

        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_len   = r_len;
        n_val   = r_val;
        n_ovf   = r_ovf;
        o_emit  = '0;

        tok_a        = '0;
        tok_a.kind   = (r_mode == MODE_NUMBER) ? KIND_NUMBER : KIND_WORD;
        tok_a.start  = POS_OUT_W'(r_start);
        tok_a.length = LEN_OUT_W'(r_len);
        tok_a.value  = (r_mode == MODE_NUMBER) ? VAL_OUT_W'(r_val) : '0;
        tok_a.sat    = r_ovf;
        has_a        = (r_mode != MODE_IDLE);
        tok_b        = '0;
        tok_b.start  = POS_OUT_W'(r_pos);
        has_b        = 1'b0;

        if (i_accept) begin
            n_pos = r_pos + 1'b1;
            if ((r_mode == MODE_NUMBER) && is_digit) begin
                if (mul_val[VW-1:VALUE_BITS] != '0) begin
                    n_val = '1;
                    n_ovf = 1'b1;
                end else begin
                    n_val = mul_val[VALUE_BITS-1:0];
                end
                if (len_full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_len = r_len + 1'b1;
                end
            end else if ((r_mode == MODE_WORD) && (is_digit || is_letter)) begin
                if (len_full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_len = r_len + 1'b1;
                end
            end else begin
                n_mode = MODE_IDLE;
                if (i_byte == CH_NUL) begin
                    tok_b.kind = KIND_EOT;
                    has_b      = 1'b1;
                    n_pos      = '0;
                    n_start    = '0;
                    n_len      = '0;
                    n_val      = '0;
                    n_ovf      = 1'b0;
                end else if (i_byte == CH_LF) begin
                    tok_b.kind = KIND_EOL;
                    has_b      = 1'b1;
                end else if ((i_byte == CH_COMMA) || (i_byte == CH_COLON)) begin
                    tok_b.kind   = KIND_SYMBOL;
                    tok_b.length = LEN_OUT_W'(1);
                    tok_b.value  = VAL_OUT_W'(i_byte);
                    has_b        = 1'b1;
                end else if (is_digit || is_letter) begin
                    n_mode  = is_digit ? MODE_NUMBER : MODE_WORD;
                    n_start = r_pos;
                    n_len   = POSITION_BITS'(1);
                    n_val   = is_digit ? VALUE_BITS'(digit_val) : '0;
                    n_ovf   = 1'b0;
                end

                // Pending token goes first, then the byte's own token.
                if (has_a) begin
                    o_emit.tok0  = tok_a;
                    o_emit.tok1  = tok_b;
                    o_emit.count = has_b ? 2'd2 : 2'd1;
                    if (has_b) begin
                        o_emit.tok1.last = 1'b1;
                    end else begin
                        o_emit.tok0.last = 1'b1;
                    end
                end else if (has_b) begin
                    o_emit.tok0      = tok_b;
                    o_emit.tok0.last = 1'b1;
                    o_emit.count     = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_val   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_val   <= n_val;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// File: hw/rtl/atok_result_fifo.sv
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Small register queue that takes up to two results per cycle and gives one.
// ----------------------------------------------------------------------------
module atok_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  atok_pkg::t_emit  i_push,
    input  logic             i_pop,
    output atok_pkg::t_token o_head,
    output logic             o_valid,
    output logic             o_space
);
    import atok_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_token           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [PTR_W-1:0] wr_ptr_next;
    logic             pop;

    assign o_valid     = (r_count != '0);
    assign o_space     = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_head      = r_mem[r_rd_ptr];
    assign pop         = i_pop && o_valid;
    assign wr_ptr_next = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push.count);
        n_rd_ptr = r_rd_ptr + PTR_W'(pop);
        n_count  = r_count + CNT_W'(i_push.count) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.tok0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.tok1;
        end
    end

endmodule

// File: hw/rtl/assembly_text_tokenizer.sv
// ----------------------------------------------------------------------------
// Assembly text tokenizer
// Turns a stream of text bytes into word, number, symbol and line tokens.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one text byte per beat in i_s_tdata. A zero
//   byte ends the text: any pending token is flushed, an end-of-text token
//   follows and the byte position starts again from zero.
//   The master channel carries one token per beat. o_m_tuser holds the kind,
//   o_m_tdata the start, length, value and saturation flag, and o_m_tlast
//   marks the final token caused by one input byte.
// Throughput:
//   The scanner handles a byte in the cycle it is accepted and writes its
//   results into a four-entry result queue, so a token is registered in the
//   queue before it shows on the master side. One byte is taken per cycle
//   while the queue has room; a byte that yields two tokens needs two master
//   beats, and the queue's room for two results sets when the slave side pauses.
// Reset and stall:
//   Reset empties the queue and returns the scanner to idle at position
//   zero. While the receiver stalls, tokens wait in the queue and o_s_tready
//   drops once fewer than two entries are free.
// ----------------------------------------------------------------------------
`include "assembly_text_tokenizer_assert.svh"

module assembly_text_tokenizer #(
    parameter int VALUE_BITS    = atok_pkg::VALUE_BITS_DEF,
    parameter int POSITION_BITS = atok_pkg::POSITION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [atok_pkg::TEXT_W-1:0] i_s_tdata,  // [7:0] text_byte
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [15:0] start_pos, [31:16] token_length, [63:32] number_value,
    // [64] saturated, [71:65] zero
    output logic [atok_pkg::DATA_W-1:0] o_m_tdata,
    output logic [atok_pkg::KIND_W-1:0] o_m_tuser,  // [2:0] token_kind
    output logic                        o_m_tlast   // last_of_run
);
    import atok_pkg::*;

    logic   s_accept;
    t_emit  emit;
    t_token head;

    assign s_accept = i_s_tvalid && o_s_tready;

    atok_scanner #(
        .VALUE_BITS    (VALUE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_scanner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_byte   (i_s_tdata),
        .o_emit   (emit)
    );

    atok_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_pop   (i_m_tready),
        .o_head  (head),
        .o_valid (o_m_tvalid),
        .o_space (o_s_tready)
    );

    assign o_m_tdata = {PAD_W'(0), head.sat, head.value, head.length, head.start};
    assign o_m_tuser = head.kind;
    assign o_m_tlast = head.last;

    // An end-of-text byte always leaves at least one token queued.
    `ATT_ASSERT(a_eot_queued, (s_accept && (i_s_tdata == CH_NUL)) |=> o_m_tvalid,
        "end of text produced no token")
    // Backpressure on the slave side only comes from a filling queue.
    `ATT_ASSERT(a_ready_needs_data, !o_s_tready |-> o_m_tvalid,
        "slave side stalled with an empty result queue")
    // Only numbers and words can carry the saturation flag.
    `ATT_ASSERT(a_sat_kind, (o_m_tvalid && o_m_tdata[FIELD_W-1]) |->
        ((o_m_tuser == KIND_WORD) || (o_m_tuser == KIND_NUMBER)),
        "saturation flag on a token that cannot saturate")
    // Reset leaves nothing in the queue.
    `ATT_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_tvalid,
        "result queue not empty after reset")

endmodule

// File: tb/assembly_text_tokenizer_test.sv
// ----------------------------------------------------------------------------
// Testbench for the assembly text tokenizer
// Feeds text bytes on the slave stream. A model of the token rules, kept in
// this file, predicts every token. Each token taken from the master stream
// is checked field by field against the oldest prediction. The stimulus is a
// short directed text, then random assembly-like lines mixed with noise and
// end-of-text bytes. Both stream sides idle at random in most phases.
// ----------------------------------------------------------------------------
module assembly_text_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import atok_pkg::*;

    typedef logic [TEXT_W-1:0] text_q_t[$];
    typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_WORD} scan_e;

    localparam logic [TEXT_W-1:0] CH_SPACE = 8'h20;
    localparam logic [TEXT_W-1:0] CH_TAB   = 8'h09;
    localparam logic [TEXT_W-1:0] CH_VT    = 8'h0B;
    localparam logic [TEXT_W-1:0] CH_FF    = 8'h0C;
    localparam logic [TEXT_W-1:0] CH_CR    = 8'h0D;
    localparam logic [TEXT_W-1:0] CH_TOP   = 8'hFF;
    localparam logic [TEXT_W-1:0] CH_GRAVE = 8'h60;
    localparam logic [VAL_OUT_W-1:0] VALUE_MAX = '1;
    localparam logic [LEN_OUT_W-1:0] LENGTH_MAX = '1;

    // Tracks the tokenizer state and holds the tokens still to come.
    class token_tracker;
        scan_e                mode;
        logic [POS_OUT_W-1:0] position;
        logic [POS_OUT_W-1:0] tok_start;
        logic [LEN_OUT_W-1:0] tok_length;
        logic [VAL_OUT_W-1:0] accum;
        logic                 clamped;
        t_token               upcoming_tokens[$];
        int                   fail_count;

        function new();
            fail_count = 0;
            restart();
        endfunction

        function void restart();
            mode       = SCAN_IDLE;
            position   = '0;
            tok_start  = '0;
            tok_length = '0;
            accum      = '0;
            clamped    = 1'b0;
        endfunction

        function int waiting();
            return upcoming_tokens.size();
        endfunction

        function void push_token(t_kind k, logic [POS_OUT_W-1:0] s,
                                 logic [LEN_OUT_W-1:0] l, logic [VAL_OUT_W-1:0] v,
                                 logic sat);
            t_token tok;
            tok.kind   = k;
            tok.start  = s;
            tok.length = l;
            tok.value  = v;
            tok.sat    = sat;
            tok.last   = 1'b0;
            upcoming_tokens.push_back(tok);
        endfunction

        function void grow_token();
            if (tok_length == LENGTH_MAX) begin
                clamped = 1'b1;
            end else begin
                tok_length = tok_length + 1'b1;
            end
        endfunction

        // Called for every accepted text byte.
        function void accept_byte(logic [TEXT_W-1:0] b);
            logic       is_digit;
            logic       is_letter;
            logic [3:0] d;
            logic       text_ended;
            int         n_old;
            is_digit   = (b >= CH_0 && b <= CH_9);
            is_letter  = (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
            d          = 4'(b - CH_0);
            text_ended = 1'b0;
            n_old      = upcoming_tokens.size();
            if (mode == SCAN_NUMBER && is_digit) begin
                if (accum > (VALUE_MAX - 32'(d)) / 32'd10) begin
                    accum   = VALUE_MAX;
                    clamped = 1'b1;
                end else begin
                    accum = accum * 32'd10 + 32'(d);
                end
                grow_token();
            end else if (mode == SCAN_WORD && (is_digit || is_letter)) begin
                grow_token();
            end else begin
                if (mode == SCAN_NUMBER) begin
                    push_token(KIND_NUMBER, tok_start, tok_length, accum, clamped);
                end else if (mode == SCAN_WORD) begin
                    push_token(KIND_WORD, tok_start, tok_length, '0, clamped);
                end
                mode = SCAN_IDLE;
                if (b == CH_NUL) begin
                    push_token(KIND_EOT, position, '0, '0, 1'b0);
                    restart();
                    text_ended = 1'b1;
                end else if (b == CH_LF) begin
                    push_token(KIND_EOL, position, '0, '0, 1'b0);
                end else if (b == CH_COMMA || b == CH_COLON) begin
                    push_token(KIND_SYMBOL, position, 16'd1, 32'(b), 1'b0);
                end else if (is_digit || is_letter) begin
                    mode       = is_digit ? SCAN_NUMBER : SCAN_WORD;
                    tok_start  = position;
                    tok_length = 16'd1;
                    accum      = is_digit ? 32'(d) : '0;
                    clamped    = 1'b0;
                end
            end
            if (!text_ended) begin
                position = position + 1'b1;
            end
            if (upcoming_tokens.size() > n_old) begin
                upcoming_tokens[upcoming_tokens.size() - 1].last = 1'b1;
            end
        endfunction

        task report_mismatch(string msg);
            fail_count++;
            if (fail_count <= 40) begin
                $display("[%0t] MISMATCH: %s", $time, msg);
            end
        endtask

        task match_token(t_token got);
            t_token want;
            if (upcoming_tokens.size() == 0) begin
                report_mismatch($sformatf("token kind %0d start %0d with none pending",
                                          got.kind, got.start));
                return;
            end
            want = upcoming_tokens.pop_front();
            if (got.kind != want.kind) begin
                report_mismatch($sformatf("kind %0d, want %0d (start %0d)",
                                          got.kind, want.kind, want.start));
            end
            if (got.start != want.start) begin
                report_mismatch($sformatf("start %0d, want %0d", got.start, want.start));
            end
            if (got.length != want.length) begin
                report_mismatch($sformatf("length %0d, want %0d (start %0d)",
                                          got.length, want.length, want.start));
            end
            if (got.value != want.value) begin
                report_mismatch($sformatf("value %0d, want %0d (start %0d)",
                                          got.value, want.value, want.start));
            end
            if (got.sat != want.sat) begin
                report_mismatch($sformatf("saturated %0b, want %0b (start %0d)",
                                          got.sat, want.sat, want.start));
            end
            if (got.last != want.last) begin
                report_mismatch($sformatf("tlast %0b, want %0b (start %0d)",
                                          got.last, want.last, want.start));
            end
        endtask
    endclass

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic [TEXT_W-1:0]   i_s_tdata  = '0;
    logic                i_m_tready = 1'b0;
    logic                o_s_tready;
    logic                o_m_tvalid;
    logic [DATA_W-1:0]   o_m_tdata;
    logic [KIND_W-1:0]   o_m_tuser;
    logic                o_m_tlast;

    token_tracker board = new();

    int sent_count  = 0;
    int burst_left  = 0;
    int gap_max     = 0;
    int rx_mode     = 0;
    bit hold_req    = 1'b0;

    assembly_text_tokenizer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [TEXT_W-1:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? CH_LO_A + 8'(r) : CH_UP_A + 8'(r - 26);
    endfunction

    function automatic logic [TEXT_W-1:0] rand_alnum();
        return ($urandom_range(0, 5) == 0) ? CH_0 + 8'($urandom_range(0, 9)) : rand_letter();
    endfunction

    function automatic void add_word(ref text_q_t q);
        int n;
        n = $urandom_range(0, 7);
        q.push_back(rand_letter());
        repeat (n) q.push_back(rand_alnum());
    endfunction

    // Up to twelve digits, so that many numbers run past the value range.
    function automatic void add_number(ref text_q_t q);
        int n;
        n = $urandom_range(1, 12);
        repeat (n) q.push_back(CH_0 + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void add_blank(ref text_q_t q);
        logic [TEXT_W-1:0] blanks[5];
        int n;
        blanks = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
        n = $urandom_range(1, 3);
        repeat (n) begin
            q.push_back(($urandom_range(0, 2) != 0) ? CH_SPACE : blanks[$urandom_range(0, 4)]);
        end
    endfunction

    // Offers one byte and holds it until the slave side takes it.
    task automatic send_byte(input logic [TEXT_W-1:0] b);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.accept_byte(b);
        sent_count++;
    endtask

    task automatic send_text(input text_q_t txt);
        int gap;
        foreach (txt[i]) begin
            if (burst_left == 0) begin
                gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                if (gap > 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            send_byte(txt[i]);
            burst_left--;
        end
    endtask

    task automatic wait_drained(input int limit);
        int n;
        n = 0;
        while (board.waiting() != 0 && n < limit) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    // Master side: checks each beat and drives tready on its own pattern.
    initial begin : token_sink
        int     hold_left;
        int     tick;
        t_token got;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.kind   = t_kind'(o_m_tuser);
                got.start  = o_m_tdata[15:0];
                got.length = o_m_tdata[31:16];
                got.value  = o_m_tdata[63:32];
                got.sat    = o_m_tdata[64];
                got.last   = o_m_tlast;
                board.match_token(got);
            end
            tick++;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= ($urandom_range(0, 9) < 7);
                    2: i_m_tready <= ((tick % 7) < 3);
                    default: i_m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        text_q_t txt;
        string   lead;
        int      sel;
        int      n_ops;
        int      goal;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Word with digits, symbols, end of line, a number running into a
        // word, every blank, bytes outside the character set, a number that
        // just reaches the top of the value range and then clamps, end of text.
        lead = "Az9,Z0:\n12ab";
        foreach (lead[i]) txt.push_back(lead[i]);
        txt = {txt, CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR, CH_TOP};
        lead = "42949672959";
        foreach (lead[i]) txt.push_back(lead[i]);
        txt = {txt, CH_GRAVE, CH_NUL};
        send_text(txt);

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin rx_mode = 0; gap_max = 0;  end
                1: begin rx_mode = 1; gap_max = 4;  end
                2: begin rx_mode = 3; gap_max = 2;  end
                3: begin rx_mode = 2; gap_max = 8;  end
                4: begin rx_mode = 1; gap_max = 0;  end
                5: begin rx_mode = 3; gap_max = 12; end
                default: begin rx_mode = 1; gap_max = 3; end
            endcase
            // The receiver stalls long while bytes keep coming, so the
            // result queue fills and the slave side backs up.
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            if (ph == 4) begin
                i_s_tvalid <= 1'b0;
                wait_drained(20000);
            end
            goal = sent_count + 140;
            while (sent_count < goal) begin
                txt = {};
                sel = $urandom_range(0, 19);
                if (sel < 15) begin
                    if ($urandom_range(0, 3) == 0) begin
                        add_word(txt);
                        txt.push_back(CH_COLON);
                        add_blank(txt);
                    end
                    add_word(txt);
                    n_ops = $urandom_range(0, 3);
                    for (int k = 0; k < n_ops; k++) begin
                        if (k > 0) begin
                            txt.push_back(CH_COMMA);
                        end
                        add_blank(txt);
                        case ($urandom_range(0, 3))
                            0: add_word(txt);
                            1, 2: add_number(txt);
                            default: begin
                                add_number(txt);
                                add_word(txt);
                            end
                        endcase
                    end
                    if ($urandom_range(0, 4) == 0) begin
                        txt.push_back(CH_CR);
                    end
                    txt.push_back(CH_LF);
                end else if (sel < 19) begin
                    repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(1, 255)));
                end else begin
                    txt.push_back(CH_NUL);
                end
                send_text(txt);
            end
        end

        i_s_tvalid <= 1'b0;
        rx_mode = 0;
        wait_drained(50000);
        repeat (16) @(posedge i_clk);
        if (board.waiting() != 0) begin
            board.report_mismatch($sformatf("%0d tokens never arrived", board.waiting()));
        end
        if (board.fail_count == 0) begin
            $display("assembly_text_tokenizer verification clean");
        end else begin
            $display("assembly_text_tokenizer verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #10ms;
        $display("assembly_text_tokenizer verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/atok_pkg.sv
hw/rtl/atok_scanner.sv
hw/rtl/atok_result_fifo.sv
hw/rtl/assembly_text_tokenizer.sv
tb/assembly_text_tokenizer_test.sv
